[hdl/assert_macros.svh]
// Assertion macros shared by the frame checker RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Clocked assertion that a condition never holds.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

[hdl/dcrfc_pkg.sv]
// Shared types and constants for the DDC/CI reply frame checker.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package dcrfc_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ADDR_W   = 7;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned STATUS_W = 3;

  // Largest payload length the frame format can carry
  localparam int unsigned MAX_FRAME_PAYLOAD = 127;

  // Protocol constants
  localparam logic [BYTE_W-1:0] XOR_SEED = 8'h50;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD    = 1'b1;
  localparam logic [ADDR_W-1:0] DEVICE_ADDRESS_RST = 7'd55;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST    = 7'd32;

  // Frame phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_LENGTH   = 4'b0010,
    PH_PAYLOAD  = 4'b0100,
    PH_CHECKSUM = 4'b1000
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_SOURCE = 3'd1,
    ST_NO_FLAG    = 3'd2,
    ST_TOO_LONG   = 3'd3,
    ST_BAD_SUM    = 3'd4
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  // One result item
  typedef struct packed {
    kind_e              kind;
    logic [BYTE_W-1:0]  payload_byte;
    logic [LEN_W-1:0]   payload_index;
    status_e            frame_status;
    logic [LEN_W-1:0]   payload_length;
  } result_t;

endpackage

`default_nettype wire

[hdl/dcrfc_if.sv]
// Valid/ready channel interfaces for received bytes and result items.
// Depends on dcrfc_pkg for field widths.
`default_nettype none

interface dcrfc_in_if;
  import dcrfc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              frame_start;

  modport source (output valid, rx_byte, frame_start, input ready);
  modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

interface dcrfc_out_if;
  import dcrfc_pkg::*;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [BYTE_W-1:0]   payload_byte;
  logic [LEN_W-1:0]    payload_index;
  logic [STATUS_W-1:0] frame_status;
  logic [LEN_W-1:0]    payload_length;

  modport source (output valid, kind, payload_byte, payload_index, frame_status,
                  payload_length, input ready);
  modport sink   (input valid, kind, payload_byte, payload_index, frame_status,
                  payload_length, output ready);
endinterface

`default_nettype wire

[hdl/dcrfc_core.sv]
// Frame state and per-byte check logic: header, payload and checksum.
// Depends on dcrfc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dcrfc_core #(
  parameter int unsigned MaxFramePayload = dcrfc_pkg::MAX_FRAME_PAYLOAD
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          acc_i,
  input  wire logic [dcrfc_pkg::BYTE_W-1:0]  rx_byte_i,
  input  wire logic                          frame_start_i,
  input  wire logic [dcrfc_pkg::ADDR_W-1:0]  device_address_i,
  input  wire logic [dcrfc_pkg::LEN_W-1:0]   max_payload_i,
  output logic                               res_valid_o,
  output dcrfc_pkg::result_t                 res_o
);
  import dcrfc_pkg::*;

  localparam int unsigned PosW = $clog2(MaxFramePayload + 1);
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MaxFramePayload);

  phase_e            phase_q, phase_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [PosW-1:0]   exp_q, exp_d;
  logic [BYTE_W-1:0] xor_q, xor_d;

  logic [LEN_W-1:0]  len;
  logic [PosW-1:0]   pos_inc;
  logic [BYTE_W-1:0] xor_next;

  assign len      = rx_byte_i[LEN_W-1:0];
  assign pos_inc  = pos_q + PosW'(1);
  assign xor_next = xor_q ^ rx_byte_i;

  // Next state and result for one accepted byte
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    exp_d       = exp_q;
    xor_d       = xor_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_STATUS, payload_byte: '0, payload_index: '0,
                    frame_status: ST_OK, payload_length: '0};
    if (acc_i) begin
      if (frame_start_i) begin
        // New frame: source byte must be twice the device address
        pos_d = '0;
        exp_d = '0;
        if (rx_byte_i != {device_address_i, 1'b0}) begin
          xor_d              = XOR_SEED;
          phase_d            = PH_IDLE;
          res_valid_o        = 1'b1;
          res_o.frame_status = ST_BAD_SOURCE;
        end else begin
          xor_d   = XOR_SEED ^ rx_byte_i;
          phase_d = PH_LENGTH;
        end
      end else begin
        unique case (phase_q)
          PH_LENGTH: begin
            if (!rx_byte_i[BYTE_W-1]) begin
              phase_d            = PH_IDLE;
              res_valid_o        = 1'b1;
              res_o.frame_status = ST_NO_FLAG;
            end else if (len > max_payload_i || len > MaxLen) begin
              phase_d              = PH_IDLE;
              res_valid_o          = 1'b1;
              res_o.frame_status   = ST_TOO_LONG;
              res_o.payload_length = len;
            end else begin
              xor_d   = xor_next;
              exp_d   = PosW'(len);
              pos_d   = '0;
              phase_d = (len == '0) ? PH_CHECKSUM : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            res_valid_o          = 1'b1;
            res_o.kind           = KIND_PAYLOAD;
            res_o.payload_byte   = rx_byte_i;
            res_o.payload_index  = LEN_W'(pos_q);
            res_o.payload_length = LEN_W'(exp_q);
            xor_d                = xor_next;
            pos_d                = pos_inc;
            if (pos_inc >= exp_q) begin
              phase_d = PH_CHECKSUM;
            end
          end
          PH_CHECKSUM: begin
            xor_d                = xor_next;
            phase_d              = PH_IDLE;
            res_valid_o          = 1'b1;
            res_o.frame_status   = (xor_next == '0) ? ST_OK : ST_BAD_SUM;
            res_o.payload_length = LEN_W'(exp_q);
          end
          default: begin
            // idle: bytes outside a frame are dropped
          end
        endcase
      end
    end
  end

  // Frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      exp_q   <= '0;
      xor_q   <= XOR_SEED;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      exp_q   <= exp_d;
      xor_q   <= xor_d;
    end
  end

  `ASSERT_CLK(a_pos_below_len, clk_i, rst_ni,
              phase_q == PH_PAYLOAD |-> pos_q < exp_q,
              "payload position reached length while still in payload phase")
  `ASSERT_CLK(a_sum_pos_eq_len, clk_i, rst_ni,
              phase_q == PH_CHECKSUM |-> pos_q == exp_q,
              "checksum phase entered before all payload bytes")
  `ASSERT_CLK(a_payload_emits, clk_i, rst_ni,
              acc_i && !frame_start_i && phase_q == PH_PAYLOAD |->
                res_valid_o && res_o.kind == KIND_PAYLOAD,
              "payload byte produced no payload result")

endmodule

`default_nettype wire

[hdl/dcrfc_out_stage.sv]
// Output register between the check logic and the result channel.
// Depends on dcrfc_pkg, dcrfc_out_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dcrfc_out_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                res_valid_i,
  input  wire dcrfc_pkg::result_t  res_i,
  output logic                     take_o,
  dcrfc_out_if.source              out_if
);
  import dcrfc_pkg::*;

  logic    out_valid_q, out_valid_d;
  result_t out_q;

  // Free when empty or when the held result transfers this cycle
  assign take_o      = !out_valid_q || out_if.ready;
  assign out_valid_d = take_o ? res_valid_i : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    if (take_o && res_valid_i) begin
      out_q <= res_i;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.kind           = out_q.kind;
  assign out_if.payload_byte   = out_q.payload_byte;
  assign out_if.payload_index  = out_q.payload_index;
  assign out_if.frame_status   = out_q.frame_status;
  assign out_if.payload_length = out_q.payload_length;

  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
                res_valid_i && out_valid_q && !out_if.ready,
                "result produced while output register is stalled")
  `ASSERT_CLK(a_result_lands, clk_i, rst_ni,
              res_valid_i |=> out_valid_q,
              "result did not reach the output register")
  `ASSERT_CLK(a_drop_only_on_take, clk_i, rst_ni,
              $fell(out_valid_q) |-> $past(out_if.ready),
              "held result dropped without a transfer")

endmodule

`default_nettype wire

[hdl/ddc_ci_reply_frame_checker.sv]
// DDC/CI reply frame checker: one byte per cycle, results in a registered stage.
// Output: a result is registered and appears on the output in the cycle after its byte transfers.
// Throughput: one byte per cycle; stalls only while a result waits on the output.
// Reset (async, active low): frame idle, XOR seed 0x50, address 55, max payload 32.
// Depends on dcrfc_pkg, dcrfc_if, dcrfc_core and dcrfc_out_stage.
`default_nettype none

module ddc_ci_reply_frame_checker #(
  parameter int unsigned MaxFramePayload = dcrfc_pkg::MAX_FRAME_PAYLOAD
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [dcrfc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [dcrfc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  dcrfc_in_if.sink                               in_if,
  dcrfc_out_if.source                            out_if
);
  import dcrfc_pkg::*;

  logic [ADDR_W-1:0] dev_addr_q;
  logic [LEN_W-1:0]  max_pay_q;
  logic              take;
  logic              acc;
  logic              res_valid;
  result_t           res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DEVICE_ADDRESS_RST;
      max_pay_q  <= MAX_PAYLOAD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEVICE_ADDRESS: dev_addr_q <= cfg_data_i[ADDR_W-1:0];
        CFG_MAX_PAYLOAD:    max_pay_q  <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_if.ready = take;
  assign acc         = in_if.valid && take;

  dcrfc_core #(
    .MaxFramePayload (MaxFramePayload)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .acc_i            (acc),
    .rx_byte_i        (in_if.rx_byte),
    .frame_start_i    (in_if.frame_start),
    .device_address_i (dev_addr_q),
    .max_payload_i    (max_pay_q),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  dcrfc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .take_o      (take),
    .out_if      (out_if)
  );

endmodule

`default_nettype wire
